// ===== rtl/prms_pkg.sv =====
// shared types and constants for the profile ratio motion scaler
// no dependencies
`default_nettype none

package prms_pkg;

  localparam int DEF_TABLE_SLOTS = 4;
  localparam int DEF_MOTION_BITS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int RATIO_W    = 16;
  localparam int KEY_W      = 8;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;
  localparam int CARRY_W    = RATIO_W + 1;
  localparam int SLOT_CNT_W = 3;

  // register indexes; slot entries sit below REG_SLOT_COUNT
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_NUM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_DEN     = 3'd6;

  localparam logic       MODE_ENDPOINT = 1'b1;
  localparam logic [1:0] AXIS_X        = 2'd0;
  localparam logic [1:0] AXIS_Y        = 2'd1;

  typedef struct packed {
    logic [RATIO_W-1:0] num;
    logic [RATIO_W-1:0] den;
  } ratio_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic mul;
    logic add;
    logic div_step;
    logic fix;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic endpoint;
    logic pass;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/prms_cfg.sv =====
// configuration registers and ratio selection
// depends on prms_pkg
`default_nettype none

module prms_cfg #(
  parameter int TABLE_SLOTS = prms_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [prms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           usb_active,
  input  wire logic [prms_pkg::KEY_W-1:0]     active_profile,
  output prms_pkg::ratio_t                    ratio
);
  import prms_pkg::*;

  localparam int SLOT_IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [CFG_DATA_W-1:0] slot [TABLE_SLOTS];
  logic [SLOT_CNT_W-1:0] slots_in_use;
  logic [RATIO_W-1:0]    fb_num;
  logic [RATIO_W-1:0]    fb_den;
  logic [SLOT_CNT_W-1:0] search_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot[i] <= '0;
      end
      slots_in_use <= '0;
      fb_num       <= RATIO_W'(1);
      fb_den       <= RATIO_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index < CFG_IDX_W'(TABLE_SLOTS)) begin
        slot[cfg_index[SLOT_IDX_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_SLOT_COUNT) begin
        slots_in_use <= cfg_data[SLOT_CNT_W-1:0];
      end else if (cfg_index == REG_FB_NUM) begin
        fb_num <= cfg_data[RATIO_W-1:0];
      end else if (cfg_index == REG_FB_DEN) begin
        fb_den <= cfg_data[RATIO_W-1:0];
      end
    end
  end

  assign search_cnt = (slots_in_use > SLOT_CNT_W'(TABLE_SLOTS)) ?
                      SLOT_CNT_W'(TABLE_SLOTS) : slots_in_use;

  // walk from the last slot down so the lowest matching slot wins
  always_comb begin
    ratio.num = fb_num;
    ratio.den = fb_den;
    if (!usb_active) begin
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
        if (SLOT_CNT_W'(i) < search_cnt &&
            slot[i][CFG_DATA_W-1 -: KEY_W] == active_profile) begin
          ratio.num = slot[i][2*RATIO_W-1:RATIO_W];
          ratio.den = slot[i][RATIO_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prms_ctrl.sv =====
// sequencing state machine for the motion scaler
// depends on prms_pkg
`default_nettype none

module prms_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  prms_pkg::dp_status_t      status,
  output prms_pkg::ctrl_cmd_t       cmd
);
  import prms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_ADD    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (status.endpoint) state_next = S_IDLE;
        else if (status.pass)         state_next = S_EMIT;
        else                          state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/prms_dp.sv =====
// datapath: item capture, endpoint state, multiply, bit-serial divider,
// per-axis remainder carry and output register; depends on prms_pkg
`default_nettype none

module prms_dp #(
  parameter int MOTION_BITS = prms_pkg::DEF_MOTION_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  prms_pkg::ctrl_cmd_t               cmd,
  output prms_pkg::dp_status_t              status,
  input  wire logic                         mode,
  input  wire logic                         is_relative,
  input  wire logic [1:0]                   axis,
  input  wire logic signed [prms_pkg::IN_W-1:0] motion_in,
  input  wire logic                         on_usb,
  input  wire logic [prms_pkg::KEY_W-1:0]   profile_number,
  input  prms_pkg::ratio_t                  ratio,
  output logic                              usb_active,
  output logic [prms_pkg::KEY_W-1:0]        active_profile,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [prms_pkg::OUT_W-1:0] motion_out,
  output logic                              was_scaled
);
  import prms_pkg::*;

  localparam int PROD_W = MOTION_BITS + RATIO_W + 1;
  localparam int TOT_W  = PROD_W + 1;
  localparam int MAG_W  = TOT_W - 1;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int SAT_W  = (TOT_W > OUT_W) ? TOT_W : OUT_W + 1;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

  // captured item
  logic                          mode_q;
  logic                          rel_q;
  logic [1:0]                    axis_q;
  logic signed [MOTION_BITS-1:0] mot_q;
  logic                          usb_q;
  logic [KEY_W-1:0]              prof_q;

  logic [RATIO_W-1:0]            num_q;
  logic [RATIO_W-1:0]            den_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [CARRY_W-1:0]     carry_x;
  logic signed [CARRY_W-1:0]     carry_y;
  logic                          neg;
  logic [MAG_W-1:0]              mag;
  logic [RATIO_W-1:0]            rem;
  logic [CNT_W-1:0]              cnt;
  logic signed [OUT_W-1:0]       result;
  logic                          result_scaled;

  logic signed [CARRY_W-1:0]     carry_sel;
  logic signed [TOT_W-1:0]       total;
  logic signed [TOT_W-1:0]       total_abs;
  logic [RATIO_W:0]              trial;
  logic                          trial_ge;
  logic signed [TOT_W-1:0]       quot_s;
  logic signed [SAT_W-1:0]       quot_ext;
  logic signed [CARRY_W-1:0]     rem_s;
  logic signed [OUT_W-1:0]       quot_sat;
  logic signed [RATIO_W+1:0]     num_s;

  assign status.endpoint = (mode_q == MODE_ENDPOINT);
  assign status.pass     = !rel_q || (axis_q != AXIS_X && axis_q != AXIS_Y) ||
                           ratio.den == '0 || ratio.num == ratio.den;
  assign status.div_last = (cnt == CNT_W'(MAG_W - 1));
  assign status.out_free = !out_valid || out_ready;

  assign num_s     = $signed({2'b00, num_q});
  assign carry_sel = (axis_q == AXIS_X) ? carry_x : carry_y;
  assign total     = TOT_W'(prod) + TOT_W'(carry_sel);
  assign total_abs = total[TOT_W-1] ? -total : total;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem, mag[MAG_W-1]};
  assign trial_ge = (trial >= {1'b0, den_q});

  // truncating division: quotient and remainder both follow the dividend sign
  assign quot_s   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign rem_s    = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
  assign quot_ext = SAT_W'(quot_s);

  always_comb begin
    priority if (quot_ext > SAT_HI) quot_sat = SAT_HI[OUT_W-1:0];
    else if (quot_ext < SAT_LO)     quot_sat = SAT_LO[OUT_W-1:0];
    else                            quot_sat = quot_ext[OUT_W-1:0];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      rel_q  <= is_relative;
      axis_q <= axis;
      mot_q  <= motion_in[MOTION_BITS-1:0];
      usb_q  <= on_usb;
      prof_q <= profile_number;
    end
    if (cmd.decode) begin
      num_q         <= ratio.num;
      den_q         <= ratio.den;
      result        <= OUT_W'(mot_q);
      result_scaled <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mot_q) * PROD_W'(num_s);
    end
    if (cmd.add) begin
      neg <= total[TOT_W-1];
      mag <= total_abs[MAG_W-1:0];
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? RATIO_W'(trial - {1'b0, den_q}) : trial[RATIO_W-1:0];
      mag <= {mag[MAG_W-2:0], trial_ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.fix) begin
      result        <= quot_sat;
      result_scaled <= 1'b1;
    end
    if (cmd.emit) begin
      motion_out <= result;
      was_scaled <= result_scaled;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      usb_active     <= 1'b0;
      active_profile <= '0;
      carry_x        <= '0;
      carry_y        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.decode && mode_q == MODE_ENDPOINT) begin
        usb_active <= usb_q;
        if (!usb_q) active_profile <= prof_q;
      end
      if (cmd.fix) begin
        if (axis_q == AXIS_X) carry_x <= rem_s;
        else                  carry_y <= rem_s;
      end
      if (cmd.emit)           out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/profile_ratio_motion_scaler.sv =====
// scaled motion item: captured, decoded, multiplied, carry added, divided by the
// restoring divider at one quotient bit per cycle, then saturated and emitted;
// pass-through item: decoded and emitted unscaled; endpoint item: no result
// one item in flight: the next transfer waits for the last item to finish; the
// output register lets it start while a result waits
// sync reset clears carries, endpoint state and config
`default_nettype none

module profile_ratio_motion_scaler #(
  parameter int TABLE_SLOTS = prms_pkg::DEF_TABLE_SLOTS,
  parameter int MOTION_BITS = prms_pkg::DEF_MOTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic                             is_relative,
  input  wire logic [1:0]                       axis,
  input  wire logic signed [prms_pkg::IN_W-1:0] motion_in,
  input  wire logic                             on_usb,
  input  wire logic [prms_pkg::KEY_W-1:0]       profile_number,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [prms_pkg::OUT_W-1:0]     motion_out,
  output logic                                  was_scaled,
  input  wire logic                             cfg_wr_en,
  input  wire logic [prms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [prms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import prms_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  ratio_t           ratio;
  logic             usb_active;
  logic [KEY_W-1:0] active_profile;

  prms_cfg #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .usb_active     (usb_active),
    .active_profile (active_profile),
    .ratio          (ratio)
  );

  prms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prms_dp #(
    .MOTION_BITS(MOTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .mode           (mode),
    .is_relative    (is_relative),
    .axis           (axis),
    .motion_in      (motion_in),
    .on_usb         (on_usb),
    .profile_number (profile_number),
    .ratio          (ratio),
    .usb_active     (usb_active),
    .active_profile (active_profile),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motion_out     (motion_out),
    .was_scaled     (was_scaled)
  );

endmodule

`default_nettype wire

// ===== tb/tb_profile_ratio_motion_scaler.sv =====
// self-checking testbench for profile_ratio_motion_scaler: directed, back-pressure
// and random traffic against an in-bench ratio predictor
// depends on rtl/prms_pkg.sv and rtl/profile_ratio_motion_scaler.sv
`timescale 1ns / 1ps

module tb_profile_ratio_motion_scaler;
  import prms_pkg::*;

  localparam int     TBL_SLOTS      = DEF_TABLE_SLOTS;
  localparam int     DRAIN_CYCLES   = 45;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     HOLD_OFF_LEN   = 300;
  localparam longint OUT_MAX        = 64'sd2147483647;
  localparam longint OUT_MIN        = -64'sd2147483648;

  localparam logic                 MODE_MOTION = ~MODE_ENDPOINT;
  localparam logic [1:0]           AXIS_OTHER  = 2'd2;
  localparam logic [1:0]           AXIS_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 3'd7;

  typedef enum int {TABLE_RANDOM, TABLE_ALL_ZERO, TABLE_ALL_ONE} table_kind_e;

  typedef struct {
    logic                     mode;
    logic                     is_rel;
    logic [1:0]               axis;
    logic signed [IN_W-1:0]   motion;
    logic                     on_usb;
    logic [KEY_W-1:0]         profile;
  } motion_event_t;

  typedef struct {
    logic signed [OUT_W-1:0] motion;
    logic                    scaled;
  } motion_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      mode = 1'b0;
  logic                      is_relative = 1'b0;
  logic [1:0]                axis = 2'd0;
  logic signed [IN_W-1:0]    motion_in = '0;
  logic                      on_usb = 1'b0;
  logic [KEY_W-1:0]          profile_number = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   motion_out;
  logic                      was_scaled;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // predictor copy of the block's registers and state
  logic [CFG_DATA_W-1:0]     slot_tbl [TBL_SLOTS];
  logic [SLOT_CNT_W-1:0]     slot_count;
  logic [RATIO_W-1:0]        fb_num;
  logic [RATIO_W-1:0]        fb_den;
  logic                      st_usb;
  logic [KEY_W-1:0]          st_profile;
  longint                    carry_x;
  longint                    carry_y;

  motion_result_t            expected_motion_q [$];
  int                        mismatches = 0;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;
  int                        hold_off_req = 0;
  int                        stuck_cycles = 0;

  profile_ratio_motion_scaler i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .is_relative    (is_relative),
    .axis           (axis),
    .motion_in      (motion_in),
    .on_usb         (on_usb),
    .profile_number (profile_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motion_out     (motion_out),
    .was_scaled     (was_scaled),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // endpoint items update state only; motion items give one result
  function automatic bit scale_motion(input motion_event_t ev, output motion_result_t res);
    longint v, num, den, total, q, r;
    int unsigned n_slots;
    bit hit;
    v = longint'(ev.motion);
    res.motion = v[31:0];
    res.scaled = 1'b0;
    if (ev.mode == MODE_ENDPOINT) begin
      if (ev.on_usb) begin
        st_usb = 1'b1;
      end else begin
        st_usb = 1'b0;
        st_profile = ev.profile;
      end
      return 1'b0;
    end
    if (!ev.is_rel || ev.axis > AXIS_Y) return 1'b1;
    num = fb_num;
    den = fb_den;
    hit = 1'b0;
    n_slots = (slot_count > TBL_SLOTS) ? TBL_SLOTS : slot_count;
    if (!st_usb) begin
      for (int i = 0; i < n_slots; i++) begin
        if (!hit && slot_tbl[i][39:32] == st_profile) begin
          num = slot_tbl[i][31:16];
          den = slot_tbl[i][15:0];
          hit = 1'b1;
        end
      end
    end
    if (den == 0 || num == den) return 1'b1;
    total = v * num + ((ev.axis == AXIS_X) ? carry_x : carry_y);
    q = total / den;
    r = total % den;
    if (ev.axis == AXIS_X) carry_x = r;
    else carry_y = r;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    res.motion = q[31:0];
    res.scaled = 1'b1;
    return 1'b1;
  endfunction

  function automatic motion_event_t motion_ev(input logic [1:0] ax, input logic rel,
                                              input logic signed [IN_W-1:0] val);
    motion_event_t ev;
    ev.mode = MODE_MOTION;
    ev.is_rel = rel;
    ev.axis = ax;
    ev.motion = val;
    ev.on_usb = $urandom_range(1);
    ev.profile = $urandom_range(255);
    return ev;
  endfunction

  function automatic motion_event_t endpoint_ev(input logic usb, input logic [KEY_W-1:0] prof);
    motion_event_t ev;
    ev = motion_ev($urandom_range(3), $urandom_range(1), $urandom_range(16'hFFFF));
    ev.mode = MODE_ENDPOINT;
    ev.on_usb = usb;
    ev.profile = prof;
    return ev;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0: return 8'hFF;
      1: return $urandom_range(255);
      default: return $urandom_range(3);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] slot_word(input logic [KEY_W-1:0] key,
                                                      input logic [RATIO_W-1:0] num,
                                                      input logic [RATIO_W-1:0] den);
    return {key, num, den};
  endfunction

  function automatic void random_ratio(output logic [RATIO_W-1:0] num,
                                       output logic [RATIO_W-1:0] den);
    case ($urandom_range(9))
      4: begin num = $urandom_range(16'hFFFF); den = $urandom_range(1, 16'hFFFF); end
      5: begin num = $urandom_range(1, 9); den = num; end
      6: begin num = $urandom_range(1, 9); den = '0; end
      7: begin num = '0; den = $urandom_range(1, 9); end
      8: begin num = 16'hFFFF; den = $urandom_range(1, 9); end
      9: begin num = $urandom_range(1, 9); den = 16'hFFFF; end
      default: begin num = $urandom_range(1, 9); den = $urandom_range(1, 9); end
    endcase
  endfunction

  function automatic motion_event_t random_event();
    motion_event_t ev;
    logic signed [IN_W-1:0] val;
    logic [1:0] ax;
    case ($urandom_range(9))
      0: val = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
      1, 2, 3: val = $urandom_range(20) - 10;
      default: val = $urandom_range(16'hFFFF);
    endcase
    ax = ($urandom_range(9) == 0) ? $urandom_range(AXIS_OTHER, AXIS_SPARE)
                                  : $urandom_range(AXIS_Y);
    ev = motion_ev(ax, $urandom_range(9) != 0, val);
    if ($urandom_range(99) < 15)
      ev = endpoint_ev($urandom_range(99) < 30,
                       $urandom_range(1) ? pick_key() : $urandom_range(255));
    return ev;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < REG_SLOT_COUNT) slot_tbl[idx] = data;
    else if (idx == REG_SLOT_COUNT) slot_count = data[SLOT_CNT_W-1:0];
    else if (idx == REG_FB_NUM) fb_num = data[RATIO_W-1:0];
    else if (idx == REG_FB_DEN) fb_den = data[RATIO_W-1:0];
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_fallback(input logic [RATIO_W-1:0] num, input logic [RATIO_W-1:0] den);
    cfg_write(REG_FB_NUM, CFG_DATA_W'(num));
    cfg_write(REG_FB_DEN, CFG_DATA_W'(den));
  endtask

  task automatic send_event(input motion_event_t ev);
    motion_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= ev.mode;
    is_relative <= ev.is_rel;
    axis <= ev.axis;
    motion_in <= ev.motion;
    on_usb <= ev.on_usb;
    profile_number <= ev.profile;
    do @(posedge clk); while (!in_ready);
    if (scale_motion(ev, res)) expected_motion_q.push_back(res);
  endtask

  // stop offering, let every result out, then cover endpoint items still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_table(input table_kind_e kind);
    logic [RATIO_W-1:0] num, den;
    logic [CFG_DATA_W-1:0] junk;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      random_ratio(num, den);
      case (kind)
        TABLE_ALL_ZERO: cfg_write(REG_SLOT0 + 3'(i), '0);
        TABLE_ALL_ONE:  cfg_write(REG_SLOT0 + 3'(i), '1);
        default:        cfg_write(REG_SLOT0 + 3'(i), slot_word(pick_key(), num, den));
      endcase
    end
    random_ratio(num, den);
    // unused upper bits of the narrow registers carry noise half the time
    junk = $urandom_range(1) ? {8'($urandom_range(255)), 32'($urandom)} : '0;
    case (kind)
      TABLE_ALL_ZERO: begin
        cfg_write(REG_SLOT_COUNT, '0);
        set_fallback('0, '0);
      end
      TABLE_ALL_ONE: begin
        cfg_write(REG_SLOT_COUNT, '1);
        set_fallback('1, '1);
      end
      default: begin
        cfg_write(REG_SLOT_COUNT, {junk[CFG_DATA_W-1:SLOT_CNT_W], 3'($urandom_range(7))});
        cfg_write(REG_FB_NUM, {junk[CFG_DATA_W-1:RATIO_W], num});
        cfg_write(REG_FB_DEN, {junk[CFG_DATA_W-1:RATIO_W], den});
      end
    endcase
    cfg_write(REG_NONE, {8'($urandom_range(255)), 32'($urandom)});
  endtask

  task automatic test_reset_state();
    send_event(motion_ev(AXIS_X, 1'b1, 16'sd5));
    send_event(endpoint_ev(1'b0, 8'd0));
    send_event(motion_ev(AXIS_Y, 1'b1, -16'sd3));
  endtask

  // remainder left by one ratio is added as is under the next one
  task automatic test_carry_saturation();
    drain();
    set_fallback(16'd2, 16'hFFFF);
    send_event(motion_ev(AXIS_X, 1'b1, -16'sd32767));
    drain();
    set_fallback(16'hFFFF, 16'd1);
    send_event(motion_ev(AXIS_X, 1'b1, -16'sh8000));
    send_event(motion_ev(AXIS_Y, 1'b1, 16'sh7FFF));
  endtask

  task automatic test_profile_table();
    drain();
    cfg_write(REG_SLOT0,        slot_word(8'd1, 16'd3, 16'd2));
    cfg_write(REG_SLOT0 + 3'd1, slot_word(8'd2, 16'd5, 16'd0));
    cfg_write(REG_SLOT0 + 3'd2, slot_word(8'd3, 16'd7, 16'd7));
    cfg_write(REG_SLOT0 + 3'd3, slot_word(8'd4, 16'hFFFF, 16'd1));
    cfg_write(REG_SLOT_COUNT, CFG_DATA_W'(5));
    set_fallback(16'd1, 16'd3);
    cfg_write(REG_NONE, '1);
    send_event(endpoint_ev(1'b0, 8'd1));
    send_event(motion_ev(AXIS_X, 1'b1, 16'sh7FFF));
    send_event(motion_ev(AXIS_X, 1'b1, -16'sh8000));
    send_event(motion_ev(AXIS_Y, 1'b1, 16'sd1));
    send_event(motion_ev(AXIS_Y, 1'b1, -16'sd1));
    send_event(motion_ev(AXIS_X, 1'b0, 16'sd100));
    send_event(motion_ev(AXIS_OTHER, 1'b1, 16'sd55));
    send_event(motion_ev(AXIS_SPARE, 1'b1, -16'sd55));
    send_event(endpoint_ev(1'b0, 8'd2));
    send_event(motion_ev(AXIS_X, 1'b1, 16'sd9));
    send_event(endpoint_ev(1'b0, 8'd3));
    send_event(motion_ev(AXIS_Y, 1'b1, 16'sd12));
    send_event(endpoint_ev(1'b0, 8'd4));
    send_event(motion_ev(AXIS_X, 1'b1, -16'sh8000));
    send_event(endpoint_ev(1'b1, 8'd9));
    send_event(motion_ev(AXIS_Y, 1'b1, 16'sh7FFF));
    send_event(endpoint_ev(1'b0, 8'd200));
    send_event(motion_ev(AXIS_X, 1'b1, 16'sd0));
    send_event(motion_ev(AXIS_X, 1'b1, -16'sd7));
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    drain();
    cfg_write(REG_SLOT_COUNT, '0);
    set_fallback(16'd5, 16'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = HOLD_OFF_LEN;
    repeat (12) send_event(motion_ev($urandom_range(AXIS_Y), 1'b1, $urandom_range(16'hFFFF)));
    drain();
  endtask

  task automatic test_random_traffic(input table_kind_e kind, input int s_pct, input int r_pct,
                                     input int n_items);
    drain();
    load_table(kind);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) send_event(random_event());
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    motion_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_motion_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: motion_out %0d was_scaled %0b", motion_out, was_scaled);
        mismatches++;
      end else begin
        want = expected_motion_q.pop_front();
        if (motion_out !== want.motion || was_scaled !== want.scaled) begin
          if (mismatches < 10)
            $display("mismatch: motion_out %0d exp %0d, was_scaled %0b exp %0b",
                     motion_out, want.motion, was_scaled, want.scaled);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && expected_motion_q.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TBL_SLOTS; i++) slot_tbl[i] = '0;
    slot_count = '0;
    fb_num = 16'd1;
    fb_den = 16'd1;
    st_usb = 1'b0;
    st_profile = '0;
    carry_x = 0;
    carry_y = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_carry_saturation();
    test_profile_table();
    test_output_hold_off();
    test_random_traffic(TABLE_RANDOM,   33, 45, 270);
    test_random_traffic(TABLE_ALL_ONE,  45, 33, 30);
    test_random_traffic(TABLE_RANDOM,   45, 33, 250);
    test_random_traffic(TABLE_ALL_ZERO, 0,  0,  30);
    test_random_traffic(TABLE_RANDOM,   0,  0,  250);
    drain();
    if (mismatches == 0 && expected_motion_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
